/* design/sjis_glyph_locator_macros.svh */
// assertion macros for the shift-jis glyph locator
// no dependencies; included by the top level
`ifndef SJIS_GLYPH_LOCATOR_MACROS_SVH
`define SJIS_GLYPH_LOCATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define SGL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("sgl same-cycle check failed");

// next-cycle implication, disabled during reset
`define SGL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("sgl next-cycle check failed");

`endif

/* design/sgl_pkg.sv */
// constants and types for the shift-jis glyph locator
// no dependencies; used by sgl_decode and sjis_glyph_locator
`timescale 1ns / 1ps

package sgl_pkg;

	// lead byte ranges
	localparam logic [7:0] LEAD_LO1 = 8'h81;
	localparam logic [7:0] LEAD_HI1 = 8'h9f;
	localparam logic [7:0] LEAD_LO2 = 8'he0;
	localparam logic [7:0] LEAD_HI2 = 8'hfc;

	// trail byte ranges
	localparam logic [7:0] TRAIL_LO1 = 8'h40;
	localparam logic [7:0] TRAIL_HI1 = 8'h7e;
	localparam logic [7:0] TRAIL_LO2 = 8'h80;
	localparam logic [7:0] TRAIL_HI2 = 8'h9e;
	localparam logic [7:0] TRAIL_LO3 = 8'h9f;

	// row/cell arithmetic
	localparam logic signed [15:0] CELLS_PER_ROW = 16'sd94;
	localparam logic signed [15:0] ROW_OFS2      = 16'sd62;
	localparam logic signed [15:0] CELL_OFS2     = 16'sd63;
	localparam logic signed [15:0] FULL_GLYPHS   = 16'sd8192;

	// pen advance per glyph
	localparam logic [15:0] ADV_HALF = 16'd6;
	localparam logic [15:0] ADV_FULL = 16'd8;

	localparam int GLYPH_W = 13;

	// decode result for one word
	typedef struct packed {
		logic               emit;
		logic               hold_lead;
		logic               full_width;
		logic [GLYPH_W-1:0] glyph_index;
		logic               out_of_range;
	} dec_t;

endpackage

/* design/sgl_decode.sv */
// byte decoder: classifies a byte against the held lead and forms the glyph number
// depends on sgl_pkg
`timescale 1ns / 1ps

module sgl_decode (
	input  logic [7:0]    code_byte,
	input  logic [7:0]    lead,
	output sgl_pkg::dec_t dec
);
	import sgl_pkg::*;

	logic                byte_is_lead;
	logic signed [15:0]  lead_s;
	logic signed [15:0]  trail_s;
	logic signed [15:0]  row;
	logic signed [15:0]  cell_num;
	logic signed [15:0]  glyph;
	logic                in_store;

	// lead byte classification
	assign byte_is_lead = (code_byte inside {[LEAD_LO1:LEAD_HI1], [LEAD_LO2:LEAD_HI2]});

	assign lead_s  = signed'({8'd0, lead});
	assign trail_s = signed'({8'd0, code_byte});

	// row and cell from lead and trail
	always_comb begin
		if (lead <= LEAD_HI1) begin
			row = (lead_s - signed'({8'd0, LEAD_LO1})) <<< 1;
		end else begin
			row = ((lead_s - signed'({8'd0, LEAD_LO2})) <<< 1) + ROW_OFS2;
		end
		if (code_byte inside {[TRAIL_LO1:TRAIL_HI1]}) begin
			cell_num = trail_s - signed'({8'd0, TRAIL_LO1});
		end else if (code_byte inside {[TRAIL_LO2:TRAIL_HI2]}) begin
			cell_num = trail_s - signed'({8'd0, TRAIL_LO2}) + CELL_OFS2;
		end else begin
			cell_num = trail_s - signed'({8'd0, TRAIL_LO3});
			row      = row + 16'sd1;
		end
	end

	// glyph number and store check
	assign glyph    = 16'(row * CELLS_PER_ROW) + cell_num;
	assign in_store = (glyph >= 16'sd0) && (glyph < FULL_GLYPHS);

	// word classification and result fields
	always_comb begin
		dec = '0;
		if (code_byte == 8'd0) begin
			dec.emit = 1'b0;
		end else if (lead == 8'd0) begin
			if (byte_is_lead) begin
				dec.hold_lead = 1'b1;
			end else begin
				dec.emit        = 1'b1;
				dec.glyph_index = {{(GLYPH_W-8){1'b0}}, code_byte};
			end
		end else begin
			dec.emit         = 1'b1;
			dec.full_width   = 1'b1;
			dec.out_of_range = !in_store;
			dec.glyph_index  = in_store ? glyph[GLYPH_W-1:0] : '0;
		end
	end

endmodule

/* design/sjis_glyph_locator.sv */
// shift-jis glyph locator: one text byte per word in, at most one glyph word out
// a byte is held in the input register, decoded, and its glyph word is loaded into the result register
// throughput: one byte per cycle unless a glyph word waits on out_ready; the pen, colour and lead
// registers update as a byte leaves the input register, so back-to-back bytes see each other's effect
// reset: arst_n clears pen, colour, held lead and both valid flags to zero
// depends on sgl_pkg, sgl_decode and sjis_glyph_locator_macros.svh
`timescale 1ns / 1ps
`include "sjis_glyph_locator_macros.svh"

module sjis_glyph_locator (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic [7:0]                code_byte,
	input  logic                      first_of_string,
	input  logic signed [15:0]        start_x,
	input  logic signed [15:0]        start_y,
	input  logic [7:0]                color,
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic                      full_width,
	output logic [sgl_pkg::GLYPH_W-1:0] glyph_index,
	output logic signed [15:0]        pen_x,
	output logic signed [15:0]        pen_y,
	output logic [7:0]                glyph_color,
	output logic                      out_of_range
);
	import sgl_pkg::*;

	// input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic [15:0] sx_s1;
	logic [15:0] sy_s1;
	logic [7:0]  col_s1;

	// decoder state
	logic [7:0]  lead_q;
	logic [15:0] cursor_x_q;
	logic [15:0] cursor_y_q;
	logic [7:0]  color_q;

	// result register
	logic               out_valid_q;
	logic               full_q;
	logic [GLYPH_W-1:0] index_q;
	logic [15:0]        pen_x_q;
	logic [15:0]        pen_y_q;
	logic [7:0]         gcol_q;
	logic               oor_q;

	logic [7:0]  lead_eff;
	logic [15:0] cur_x_eff;
	logic [15:0] cur_y_eff;
	logic [7:0]  col_eff;
	logic [15:0] step;
	logic [15:0] cur_x_next;
	logic        advance;
	logic        lead_ok;
	dec_t        dec;

	// new string reloads pen and colour and drops the lead before decoding
	assign lead_eff  = first_s1 ? 8'd0  : lead_q;
	assign cur_x_eff = first_s1 ? sx_s1 : cursor_x_q;
	assign cur_y_eff = first_s1 ? sy_s1 : cursor_y_q;
	assign col_eff   = first_s1 ? col_s1 : color_q;

	sgl_decode u_decode (
		.code_byte (byte_s1),
		.lead      (lead_eff),
		.dec       (dec)
	);

	assign step       = dec.full_width ? ADV_FULL : ADV_HALF;
	assign cur_x_next = cur_x_eff + step;

	// a word leaves the input register unless it emits a glyph word while the result register is full and out_ready is low
	assign advance  = valid_s1 && (!dec.emit || !out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1  <= code_byte;
			first_s1 <= first_of_string;
			sx_s1    <= start_x;
			sy_s1    <= start_y;
			col_s1   <= color;
		end
	end

	// pen, colour and lead state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q     <= 8'd0;
			cursor_x_q <= 16'd0;
			cursor_y_q <= 16'd0;
			color_q    <= 8'd0;
		end else if (advance) begin
			lead_q     <= dec.hold_lead ? byte_s1 : 8'd0;
			cursor_x_q <= dec.emit ? cur_x_next : cur_x_eff;
			cursor_y_q <= cur_y_eff;
			color_q    <= col_eff;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && dec.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dec.emit) begin
			full_q  <= dec.full_width;
			index_q <= dec.glyph_index;
			pen_x_q <= cur_x_eff;
			pen_y_q <= cur_y_eff;
			gcol_q  <= col_eff;
			oor_q   <= dec.out_of_range;
		end
	end

	assign out_valid    = out_valid_q;
	assign full_width   = full_q;
	assign glyph_index  = index_q;
	assign pen_x        = signed'(pen_x_q);
	assign pen_y        = signed'(pen_y_q);
	assign glyph_color  = gcol_q;
	assign out_of_range = oor_q;

	// a nonzero held lead always lies in one of the lead ranges
	assign lead_ok = (lead_q inside {[LEAD_LO1:LEAD_HI1], [LEAD_LO2:LEAD_HI2]});

	// checks
	`SGL_ASSERT_NOW(a_oor_full, clk, arst_n, out_valid_q && oor_q, full_q && (index_q == '0))
	`SGL_ASSERT_NOW(a_lead_valid, clk, arst_n, lead_q != 8'd0, lead_ok)
	`SGL_ASSERT_NEXT(a_pen_step, clk, arst_n, advance && dec.emit, cursor_x_q == $past(cur_x_next))
	`SGL_ASSERT_NEXT(a_out_load, clk, arst_n, advance && dec.emit, out_valid_q && (pen_x_q == $past(cur_x_eff)))

endmodule

/* verif/sjis_glyph_locator_tb.sv */
// self-checking testbench for sjis_glyph_locator: directed table, then random text streams
// predicts glyph words in-bench or takes typed ones; depends on sgl_pkg and the sjis_glyph_locator rtl
`timescale 1ns / 1ps

module sjis_glyph_locator_tb;
	import sgl_pkg::*;

	localparam int RAND_PER_PHASE = 320;
	localparam int CYCLE_LIMIT    = 200000;
	localparam int DRAIN_CYCLES   = 8;

	// one glyph word as the block reports it
	typedef struct packed {
		logic                      full_width;
		logic [GLYPH_W-1:0]        glyph_index;
		logic signed [15:0]        pen_x;
		logic signed [15:0]        pen_y;
		logic [7:0]                glyph_color;
		logic                      out_of_range;
	} glyph_t;

	// one text byte word plus an optional hand-typed expectation
	typedef struct {
		logic [7:0]         code;
		logic               first;
		logic signed [15:0] sx;
		logic signed [15:0] sy;
		logic [7:0]         col;
		bit                 typed;
		bit                 has_glyph;
		glyph_t             glyph;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	stim_row_t cur_row;

	logic [7:0]         code_byte;
	logic               first_of_string;
	logic signed [15:0] start_x;
	logic signed [15:0] start_y;
	logic [7:0]         color;
	logic               full_width;
	logic [GLYPH_W-1:0] glyph_index;
	logic signed [15:0] pen_x;
	logic signed [15:0] pen_y;
	logic [7:0]         glyph_color;
	logic               out_of_range;

	assign code_byte       = cur_row.code;
	assign first_of_string = cur_row.first;
	assign start_x         = cur_row.sx;
	assign start_y         = cur_row.sy;
	assign color           = cur_row.col;

	sjis_glyph_locator u_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.code_byte       (code_byte),
		.first_of_string (first_of_string),
		.start_x         (start_x),
		.start_y         (start_y),
		.color           (color),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.full_width      (full_width),
		.glyph_index     (glyph_index),
		.pen_x           (pen_x),
		.pen_y           (pen_y),
		.glyph_color     (glyph_color),
		.out_of_range    (out_of_range)
	);

	always #2 clk = ~clk;

	// predicted text state
	logic [7:0]  lead_q     = 8'h00;
	logic [15:0] cursor_x_q = 16'h0000;
	logic [15:0] cursor_y_q = 16'h0000;
	logic [7:0]  color_q    = 8'h00;

	glyph_t expected_glyphs[$];
	int     mismatches  = 0;
	int     cycle_count = 0;
	int     idle_pct    = 0;
	int     stall_pct   = 0;
	bit     gen_lead_open = 1'b0;

	function automatic bit is_lead_byte(input logic [7:0] b);
		return (b >= LEAD_LO1 && b <= LEAD_HI1) || (b >= LEAD_LO2 && b <= LEAD_HI2);
	endfunction

	// decode one text byte; returns 1 when it produces a glyph word
	function automatic bit locate_glyph(input stim_row_t r, output glyph_t g);
		int k, t, idx;
		logic [15:0] adv;
		g = '0;
		if (r.first) begin
			cursor_x_q = r.sx;
			cursor_y_q = r.sy;
			color_q    = r.col;
			lead_q     = 8'h00;
		end
		if (r.code == 8'h00) begin
			lead_q = 8'h00;
			return 1'b0;
		end
		if (lead_q == 8'h00) begin
			if (is_lead_byte(r.code)) begin
				lead_q = r.code;
				return 1'b0;
			end
			g.glyph_index = GLYPH_W'(r.code);
			adv = ADV_HALF;
		end else begin
			// row from the lead, cell from the trail; trails outside 0x40-0x7e and 0x80-0x9e move to the next row
			if (lead_q <= LEAD_HI1)
				k = 2 * (int'(lead_q) - int'(LEAD_LO1));
			else
				k = 2 * (int'(lead_q) - int'(LEAD_LO2)) + int'(ROW_OFS2);
			if (r.code >= TRAIL_LO1 && r.code <= TRAIL_HI1) begin
				t = int'(r.code) - int'(TRAIL_LO1);
			end else if (r.code >= TRAIL_LO2 && r.code <= TRAIL_HI2) begin
				t = int'(r.code) - int'(TRAIL_LO2) + int'(CELL_OFS2);
			end else begin
				t = int'(r.code) - int'(TRAIL_LO3);
				k = k + 1;
			end
			idx = k * int'(CELLS_PER_ROW) + t;
			if (idx < 0 || idx >= int'(FULL_GLYPHS)) begin
				g.out_of_range = 1'b1;
				idx = 0;
			end
			g.full_width  = 1'b1;
			g.glyph_index = idx[GLYPH_W-1:0];
			lead_q = 8'h00;
			adv = ADV_FULL;
		end
		g.pen_x       = cursor_x_q;
		g.pen_y       = cursor_y_q;
		g.glyph_color = color_q;
		cursor_x_q    = cursor_x_q + adv;
		return 1'b1;
	endfunction

	function automatic void check_field(input string name, input longint exp, input longint act);
		if (exp !== act) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			mismatches++;
		end
	endfunction

	// predict on every accepted byte, compare every accepted glyph word
	always @(posedge clk) begin : scoreboard
		glyph_t pred;
		glyph_t seen;
		bit     emits;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				emits = locate_glyph(cur_row, pred);
				if (cur_row.typed) begin
					emits = cur_row.has_glyph;
					pred  = cur_row.glyph;
				end
				if (emits)
					expected_glyphs.push_back(pred);
			end
			if (out_valid && out_ready) begin
				seen = '{full_width, glyph_index, pen_x, pen_y, glyph_color, out_of_range};
				if (expected_glyphs.size() == 0) begin
					$error("glyph word with none expected: index %0d", glyph_index);
					mismatches++;
				end else begin
					pred = expected_glyphs.pop_front();
					check_field("full_width", pred.full_width, seen.full_width);
					check_field("glyph_index", pred.glyph_index, seen.glyph_index);
					check_field("pen_x", $signed(pred.pen_x), $signed(seen.pen_x));
					check_field("pen_y", $signed(pred.pen_y), $signed(seen.pen_y));
					check_field("glyph_color", pred.glyph_color, seen.glyph_color);
					check_field("out_of_range", pred.out_of_range, seen.out_of_range);
				end
			end
		end
	end

	// receiver back-pressure
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= stall_pct);

	// watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// row checked by the predictor only
	function automatic stim_row_t row_p(input logic [7:0] code, input logic first,
			input logic signed [15:0] sx, input logic signed [15:0] sy, input logic [7:0] col);
		stim_row_t r;
		r.code = code;
		r.first = first;
		r.sx = sx;
		r.sy = sy;
		r.col = col;
		r.typed = 1'b0;
		r.has_glyph = 1'b0;
		r.glyph = '0;
		return r;
	endfunction

	// row with a hand-typed expectation
	function automatic stim_row_t row_t(input logic [7:0] code, input logic first,
			input logic signed [15:0] sx, input logic signed [15:0] sy, input logic [7:0] col,
			input bit has, input glyph_t g);
		stim_row_t r;
		r = row_p(code, first, sx, sy, col);
		r.typed = 1'b1;
		r.has_glyph = has;
		r.glyph = g;
		return r;
	endfunction

	// mostly well-formed text: leads followed by proper trails, plus noise
	function automatic stim_row_t random_row();
		stim_row_t r;
		int pick;
		r = row_p(8'h00, ($urandom_range(15) == 0), 16'($urandom), 16'($urandom),
			8'($urandom));
		pick = $urandom_range(99);
		if (gen_lead_open && !r.first && pick < 85) begin
			case ($urandom_range(2))
				0: r.code = 8'($urandom_range(TRAIL_HI1, TRAIL_LO1));
				1: r.code = 8'($urandom_range(TRAIL_HI2, TRAIL_LO2));
				default: r.code = 8'($urandom_range(LEAD_HI2, TRAIL_LO3));
			endcase
		end else if (pick < 40) begin
			r.code = $urandom_range(1) ? 8'($urandom_range(LEAD_HI1, LEAD_LO1))
				: 8'($urandom_range(LEAD_HI2, LEAD_LO2));
		end else if (pick < 80) begin
			r.code = $urandom_range(1) ? 8'($urandom_range(8'h7e, 8'h20))
				: 8'($urandom_range(8'hdf, 8'ha1));
		end else if (pick < 85) begin
			r.code = 8'h00;
		end else begin
			r.code = 8'($urandom_range(255));
		end
		if (r.first || !gen_lead_open)
			gen_lead_open = is_lead_byte(r.code);
		else
			gen_lead_open = 1'b0;
		return r;
	endfunction

	// present one byte word and wait for its acceptance
	task automatic send_row(input stim_row_t r);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		cur_row  <= r;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// hold the sender off until every glyph word is back
	task automatic drain_glyphs();
		in_valid <= 1'b0;
		do
			@(posedge clk);
		while (expected_glyphs.size() != 0);
	endtask

	initial begin : stimulus
		stim_row_t dir_rows[$];
		int idle_by_phase[4];
		int stall_by_phase[4];

		idle_by_phase  = '{0, 64, 0, 7};
		stall_by_phase = '{0, 0, 64, 7};
		arst_n   = 1'b0;
		in_valid = 1'b0;
		cur_row  = row_p(8'h00, 1'b0, 16'sd0, 16'sd0, 8'h00);

		// directed text: extremes, both tables, zero byte, new string, odd trails
		dir_rows.push_back(row_t(8'h41, 1'b0, 16'sd0, 16'sd0, 8'h00, 1'b1,
			'{1'b0, 13'd65, 16'sd0, 16'sd0, 8'h00, 1'b0}));
		dir_rows.push_back(row_t(8'h7f, 1'b1, 16'sh7fff, 16'sh8000, 8'hff, 1'b1,
			'{1'b0, 13'd127, 16'sh7fff, 16'sh8000, 8'hff, 1'b0}));
		dir_rows.push_back(row_t(8'hff, 1'b0, 16'sd0, 16'sd0, 8'h00, 1'b1,
			'{1'b0, 13'd255, 16'sh8005, 16'sh8000, 8'hff, 1'b0}));
		dir_rows.push_back(row_t(8'h81, 1'b0, 16'sd0, 16'sd0, 8'h00, 1'b0, '0));
		dir_rows.push_back(row_t(8'h40, 1'b0, 16'sd0, 16'sd0, 8'h00, 1'b1,
			'{1'b1, 13'd0, 16'sh800b, 16'sh8000, 8'hff, 1'b0}));
		dir_rows.push_back(row_t(8'hfc, 1'b0, 16'sd0, 16'sd0, 8'h00, 1'b0, '0));
		dir_rows.push_back(row_t(8'hfc, 1'b0, 16'sd0, 16'sd0, 8'h00, 1'b1,
			'{1'b1, 13'd0, 16'sh8013, 16'sh8000, 8'hff, 1'b1}));
		dir_rows.push_back(row_t(8'h81, 1'b0, 16'sd0, 16'sd0, 8'h00, 1'b0, '0));
		dir_rows.push_back(row_t(8'h01, 1'b0, 16'sd0, 16'sd0, 8'h00, 1'b1,
			'{1'b1, 13'd0, 16'sh801b, 16'sh8000, 8'hff, 1'b1}));
		dir_rows.push_back(row_p(8'h9f, 1'b0, 16'sd0, 16'sd0, 8'h00));
		dir_rows.push_back(row_p(8'h9e, 1'b0, 16'sd0, 16'sd0, 8'h00));
		dir_rows.push_back(row_p(8'he0, 1'b0, 16'sd0, 16'sd0, 8'h00));
		dir_rows.push_back(row_p(8'h9f, 1'b0, 16'sd0, 16'sd0, 8'h00));
		dir_rows.push_back(row_p(8'hef, 1'b0, 16'sd0, 16'sd0, 8'h00));
		dir_rows.push_back(row_p(8'h7e, 1'b0, 16'sd0, 16'sd0, 8'h00));
		dir_rows.push_back(row_p(8'h88, 1'b0, 16'sd0, 16'sd0, 8'h00));
		dir_rows.push_back(row_p(8'h00, 1'b0, 16'sd0, 16'sd0, 8'h00));
		dir_rows.push_back(row_p(8'h41, 1'b0, 16'sd0, 16'sd0, 8'h00));
		dir_rows.push_back(row_t(8'h82, 1'b0, 16'sd0, 16'sd0, 8'h00, 1'b0, '0));
		dir_rows.push_back(row_t(8'h42, 1'b1, 16'sh8000, 16'sh7fff, 8'h00, 1'b1,
			'{1'b0, 13'd66, 16'sh8000, 16'sh7fff, 8'h00, 1'b0}));
		dir_rows.push_back(row_t(8'h00, 1'b1, 16'sd100, -16'sd100, 8'h5a, 1'b0, '0));
		dir_rows.push_back(row_t(8'h80, 1'b0, 16'sd0, 16'sd0, 8'h00, 1'b1,
			'{1'b0, 13'd128, 16'sd100, -16'sd100, 8'h5a, 1'b0}));
		dir_rows.push_back(row_p(8'ha0, 1'b0, 16'sd0, 16'sd0, 8'h00));
		dir_rows.push_back(row_p(8'he5, 1'b1, -16'sd1, -16'sd1, 8'h01));
		dir_rows.push_back(row_p(8'hff, 1'b0, 16'sd0, 16'sd0, 8'h00));

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// one idling pattern per phase, drained in between
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct  = idle_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			if (ph == 0) begin
				foreach (dir_rows[i])
					send_row(dir_rows[i]);
			end
			for (int n = 0; n < RAND_PER_PHASE; n++) begin
				send_row(random_row());
				if ($urandom_range(199) == 0)
					drain_glyphs();
			end
			drain_glyphs();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
